>>> hw/rtl/vtm_pkg.sv
// Package for the versioned transactional memory unit.
// Holds the command codes, sizing constants and sequencer state type; no dependencies.
package vtm_pkg;

  localparam int unsigned DefaultEntries  = 128;
  localparam int unsigned DefaultContexts = 4;
  localparam int unsigned CmdWidth        = 2;
  localparam int unsigned CtxWidth        = 2;
  localparam int unsigned IdxWidth        = 7;
  localparam int unsigned DataWidth       = 32;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_COMMIT = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ACCESS,
    ST_READ_RESP,
    ST_CHECK_REQ,
    ST_CHECK,
    ST_APPLY_REQ,
    ST_APPLY,
    ST_MARK_CLEAR,
    ST_DONE
  } state_e;

endpackage

>>> hw/rtl/vtm_mark_store.sv
// Per-context read and write marks plus the write buffer of one context set.
// Marks are memories with one bit per context in each entry word; the top level
// zeroes them with a clearing pass over every entry after reset. Uses vtm_pkg.
module vtm_mark_store #(
  parameter int unsigned Entries  = vtm_pkg::DefaultEntries,
  parameter int unsigned Contexts = vtm_pkg::DefaultContexts,
  localparam int unsigned EW = (Entries > 1) ? $clog2(Entries) : 1,
  localparam int unsigned CW = (Contexts > 1) ? $clog2(Contexts) : 1
) (
  input  logic                           clk_i,
  input  logic [CW-1:0]                  ctx_i,
  input  logic [EW-1:0]                  entry_i,
  input  logic                           set_read_i,
  input  logic                           set_write_i,
  input  logic                           clear_ctx_i,
  input  logic                           clear_all_i,
  input  logic [vtm_pkg::DataWidth-1:0]  wdata_i,
  output logic                           read_mark_o,
  output logic                           write_mark_o,
  output logic [vtm_pkg::DataWidth-1:0]  buf_data_o
);

  localparam int unsigned MarkWidth = 1 << CW;
  localparam int unsigned BufDepth  = 1 << (CW + EW);

  logic [MarkWidth-1:0]          rmark_mem [Entries];
  logic [MarkWidth-1:0]          wmark_mem [Entries];
  logic [MarkWidth-1:0]          rmark_rd_q;
  logic [MarkWidth-1:0]          wmark_rd_q;
  logic [vtm_pkg::DataWidth-1:0] buf_mem [BufDepth];
  logic [CW+EW-1:0]              addr;

  assign addr = {ctx_i, entry_i};

  // Mark words: one entry written per cycle, registered read at the same entry.
  always_ff @(posedge clk_i) begin
    if (clear_all_i) begin
      rmark_mem[entry_i] <= '0;
      wmark_mem[entry_i] <= '0;
    end else if (clear_ctx_i) begin
      rmark_mem[entry_i][ctx_i] <= 1'b0;
      wmark_mem[entry_i][ctx_i] <= 1'b0;
    end else begin
      if (set_read_i)  rmark_mem[entry_i][ctx_i] <= 1'b1;
      if (set_write_i) wmark_mem[entry_i][ctx_i] <= 1'b1;
    end
    rmark_rd_q <= rmark_mem[entry_i];
    wmark_rd_q <= wmark_mem[entry_i];
  end

  assign read_mark_o  = rmark_rd_q[ctx_i];
  assign write_mark_o = wmark_rd_q[ctx_i];

  // Write buffer with registered read.
  always_ff @(posedge clk_i) begin
    if (set_write_i) buf_mem[addr] <= wdata_i;
    buf_data_o <= buf_mem[addr];
  end

endmodule

>>> hw/rtl/vtm_shared_store.sv
// Shared store of values and versions with one write and one registered read port.
// A clearing pass after reset zeroes it; uses vtm_pkg.
module vtm_shared_store #(
  parameter int unsigned Entries = vtm_pkg::DefaultEntries,
  localparam int unsigned EW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                          clk_i,
  input  logic [EW-1:0]                 addr_i,
  input  logic                          we_i,
  input  logic [vtm_pkg::DataWidth-1:0] wvalue_i,
  input  logic [vtm_pkg::DataWidth-1:0] wversion_i,
  output logic [vtm_pkg::DataWidth-1:0] rvalue_o,
  output logic [vtm_pkg::DataWidth-1:0] rversion_o
);

  logic [vtm_pkg::DataWidth-1:0] val_mem [Entries];
  logic [vtm_pkg::DataWidth-1:0] ver_mem [Entries];

  // One write port, registered read at the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      val_mem[addr_i] <= wvalue_i;
      ver_mem[addr_i] <= wversion_i;
    end
    rvalue_o   <= val_mem[addr_i];
    rversion_o <= ver_mem[addr_i];
  end

endmodule

>>> hw/rtl/versioned_transactional_memory_unit.sv
// Top level of the versioned transactional memory unit.
// Instantiates vtm_shared_store and vtm_mark_store; uses vtm_pkg.
//
// One item is handled at a time and exactly one result item follows each input
// item. After reset a clearing pass over every entry zeroes the shared store and
// all marks; no item is accepted meanwhile. Start walks every entry to clear the
// context's marks. Commit walks every entry through the single store port twice
// (check, then apply) and once more to clear marks; when it aborts it skips the
// apply walk. The block is ready again in the cycle the result appears; a result
// that has not been taken holds the next item in its final cycle until it is. An
// unknown context, or an out-of-range index on read or write, gives read_data 0
// and aborted 0. Comparisons of versions are unsigned; the global clock wraps at 2^32.
module versioned_transactional_memory_unit #(
  parameter int unsigned ENTRIES  = vtm_pkg::DefaultEntries,
  parameter int unsigned CONTEXTS = vtm_pkg::DefaultContexts
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [vtm_pkg::CmdWidth-1:0]         command_i,
  input  logic [vtm_pkg::CtxWidth-1:0]         context_req_i,
  input  logic [vtm_pkg::IdxWidth-1:0]         index_i,
  input  logic signed [vtm_pkg::DataWidth-1:0] write_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [vtm_pkg::DataWidth-1:0] read_data_o,
  output logic                                 aborted_o
);

  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int unsigned DW = vtm_pkg::DataWidth;
  localparam logic [EW:0] LastEntry = (EW+1)'(ENTRIES - 1);

  vtm_pkg::state_e state_q, state_d;

  // Captured item.
  vtm_pkg::cmd_e    cmd_q;
  logic [CW-1:0]    ctx_q;
  logic [EW-1:0]    idx_q;
  logic [DW-1:0]    wdata_q;
  logic             ctx_ok_q, idx_ok_q;

  logic [EW-1:0]    walk_q, walk_d;
  logic             fail_q, fail_d;
  logic [DW-1:0]    clock_q;
  logic [DW-1:0]    start_q [CONTEXTS];
  logic [DW-1:0]    rdata_q;
  logic             abort_q;
  logic             out_valid_q;
  logic [DW-1:0]    res_data_q;
  logic             res_abort_q;

  // Shared store port.
  logic [EW-1:0]    st_addr;
  logic             st_we;
  logic [DW-1:0]    st_wvalue, st_wversion, st_rvalue, st_rversion;

  // Mark store port.
  logic [EW-1:0]    mk_entry;
  logic             mk_set_read, mk_set_write, mk_clear, mk_clear_all;
  logic             rmark, wmark;
  logic [DW-1:0]    buf_data;

  logic             accept, in_ok_ctx, in_ok_idx, too_new, walk_last, out_free;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ok_ctx  = (32'(context_req_i) < CONTEXTS);
  assign in_ok_idx  = (32'(index_i) < ENTRIES);
  assign too_new    = st_rversion >= start_q[ctx_q];
  assign walk_last  = ({1'b0, walk_q} == LastEntry);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == vtm_pkg::ST_IDLE);

  vtm_shared_store #(.Entries(ENTRIES)) u_store (
    .clk_i      (clk_i),
    .addr_i     (st_addr),
    .we_i       (st_we),
    .wvalue_i   (st_wvalue),
    .wversion_i (st_wversion),
    .rvalue_o   (st_rvalue),
    .rversion_o (st_rversion)
  );

  vtm_mark_store #(.Entries(ENTRIES), .Contexts(CONTEXTS)) u_marks (
    .clk_i        (clk_i),
    .ctx_i        (ctx_q),
    .entry_i      (mk_entry),
    .set_read_i   (mk_set_read),
    .set_write_i  (mk_set_write),
    .clear_ctx_i  (mk_clear),
    .clear_all_i  (mk_clear_all),
    .wdata_i      (wdata_q),
    .read_mark_o  (rmark),
    .write_mark_o (wmark),
    .buf_data_o   (buf_data)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    walk_d  = walk_q;
    fail_d  = fail_q;
    unique case (state_q)
      vtm_pkg::ST_CLEAR: begin
        walk_d = walk_q + 1'b1;
        if (walk_last) state_d = vtm_pkg::ST_IDLE;
      end
      vtm_pkg::ST_IDLE: begin
        if (accept) state_d = vtm_pkg::ST_ACCESS;
      end
      vtm_pkg::ST_ACCESS: begin
        walk_d = '0;
        fail_d = 1'b0;
        if (!ctx_ok_q) state_d = vtm_pkg::ST_DONE;
        else if (cmd_q == vtm_pkg::CMD_START) state_d = vtm_pkg::ST_MARK_CLEAR;
        else if (cmd_q == vtm_pkg::CMD_READ && idx_ok_q) state_d = vtm_pkg::ST_READ_RESP;
        else if (cmd_q == vtm_pkg::CMD_COMMIT) state_d = vtm_pkg::ST_CHECK_REQ;
        else state_d = vtm_pkg::ST_DONE;
      end
      vtm_pkg::ST_READ_RESP: state_d = vtm_pkg::ST_DONE;
      vtm_pkg::ST_CHECK_REQ: state_d = vtm_pkg::ST_CHECK;
      vtm_pkg::ST_CHECK: begin
        if ((rmark || wmark) && too_new) fail_d = 1'b1;
        if (walk_last) begin
          walk_d  = '0;
          state_d = vtm_pkg::ST_APPLY_REQ;
        end else begin
          walk_d  = walk_q + 1'b1;
          state_d = vtm_pkg::ST_CHECK_REQ;
        end
      end
      vtm_pkg::ST_APPLY_REQ: begin
        if (fail_q) begin
          walk_d  = '0;
          state_d = vtm_pkg::ST_MARK_CLEAR;
        end else begin
          state_d = vtm_pkg::ST_APPLY;
        end
      end
      vtm_pkg::ST_APPLY: begin
        if (walk_last) begin
          walk_d  = '0;
          state_d = vtm_pkg::ST_MARK_CLEAR;
        end else begin
          walk_d  = walk_q + 1'b1;
          state_d = vtm_pkg::ST_APPLY_REQ;
        end
      end
      vtm_pkg::ST_MARK_CLEAR: begin
        walk_d = walk_q + 1'b1;
        if (walk_last) state_d = vtm_pkg::ST_DONE;
      end
      vtm_pkg::ST_DONE: begin
        if (out_free) state_d = vtm_pkg::ST_IDLE;
      end
      default: state_d = vtm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer toward the two stores.
  always_comb begin
    st_addr      = walk_q;
    st_we        = 1'b0;
    st_wvalue    = buf_data;
    st_wversion  = clock_q;
    mk_entry     = walk_q;
    mk_set_read  = 1'b0;
    mk_set_write = 1'b0;
    mk_clear     = 1'b0;
    mk_clear_all = 1'b0;
    unique case (state_q)
      vtm_pkg::ST_CLEAR: begin
        st_we        = 1'b1;
        st_wvalue    = '0;
        st_wversion  = '0;
        mk_clear_all = 1'b1;
      end
      vtm_pkg::ST_ACCESS: begin
        st_addr      = idx_q;
        mk_entry     = idx_q;
        mk_set_write = ctx_ok_q && idx_ok_q && (cmd_q == vtm_pkg::CMD_WRITE);
      end
      vtm_pkg::ST_READ_RESP: begin
        st_addr     = idx_q;
        mk_entry    = idx_q;
        mk_set_read = !wmark && !too_new;
      end
      vtm_pkg::ST_APPLY: st_we = wmark;
      vtm_pkg::ST_MARK_CLEAR: mk_clear = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vtm_pkg::ST_CLEAR;
      walk_q      <= '0;
      fail_q      <= 1'b0;
      clock_q     <= DW'(1);
      out_valid_q <= 1'b0;
      for (int unsigned c = 0; c < CONTEXTS; c++) start_q[c] <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      fail_q  <= fail_d;
      if (state_q == vtm_pkg::ST_ACCESS && ctx_ok_q && cmd_q == vtm_pkg::CMD_START) begin
        start_q[ctx_q] <= clock_q;
      end
      if (state_q == vtm_pkg::ST_MARK_CLEAR && walk_last && cmd_q == vtm_pkg::CMD_COMMIT &&
          !fail_q) begin
        clock_q <= clock_q + 1'b1;
      end
      if (state_q == vtm_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Item capture and working result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= vtm_pkg::cmd_e'(command_i);
      ctx_q    <= CW'(context_req_i);
      idx_q    <= EW'(index_i);
      wdata_q  <= write_data_i;
      ctx_ok_q <= in_ok_ctx;
      idx_ok_q <= in_ok_idx;
      rdata_q  <= '0;
      abort_q  <= 1'b0;
    end
    if (state_q == vtm_pkg::ST_READ_RESP) begin
      if (wmark) rdata_q <= buf_data;
      else if (too_new) abort_q <= 1'b1;
      else rdata_q <= st_rvalue;
    end
    if (state_q == vtm_pkg::ST_MARK_CLEAR) abort_q <= fail_q;
  end

  // Output register: holds the offered result so the next item can start.
  always_ff @(posedge clk_i) begin
    if (state_q == vtm_pkg::ST_DONE && out_free) begin
      res_data_q  <= rdata_q;
      res_abort_q <= abort_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = res_data_q;
  assign aborted_o   = res_abort_q;

endmodule
